FILE: rtl/core/ss7_routing_label_codec_defines.svh
// ----------------------------------------------------------------------------
// SS7 routing label codec: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SS7_ROUTING_LABEL_CODEC_DEFINES_SVH
`define SS7_ROUTING_LABEL_CODEC_DEFINES_SVH

// same-cycle implication
`define SS7RL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ss7 routing label check failed");

// next-cycle implication
`define SS7RL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ss7 routing label check failed");

`endif

FILE: rtl/core/ss7rl_pkg.sv
// ----------------------------------------------------------------------------
// SS7 routing label codec package
// Format codes, label lengths and the item/result types.
// ----------------------------------------------------------------------------
package ss7rl_pkg;

  typedef enum logic [2:0] {
    FMT_ITU    = 3'd0,
    FMT_ANSI   = 3'd1,
    FMT_ANSI8  = 3'd2,
    FMT_CHINA  = 3'd3,
    FMT_JAPAN  = 3'd4,
    FMT_JAPAN5 = 3'd5
  } fmt_t;

  localparam logic [2:0] LEN_ITU   = 3'd4;
  localparam logic [2:0] LEN_JAPAN = 3'd5;
  localparam logic [2:0] LEN_WIDE  = 3'd7;

  localparam logic MODE_DECODE = 1'b0;

  typedef struct packed {
    logic        mode;
    logic [55:0] label_bytes;
    logic [23:0] dest_code;
    logic [23:0] orig_code;
    logic [7:0]  link_select;
    logic [7:0]  spare;
  } item_t;

  typedef struct packed {
    logic [55:0] label;
    logic [2:0]  label_length;
    logic [23:0] dest_code;
    logic [23:0] orig_code;
    logic [7:0]  link_select;
    logic [2:0]  spare;
    logic        fits_format;
  } result_t;

endpackage

FILE: rtl/core/ss7rl_codec.sv
// ----------------------------------------------------------------------------
// SS7 routing label slicer/packer
// Combinational decode or encode of one routing label in the selected format.
// ----------------------------------------------------------------------------
module ss7rl_codec (
  input  ss7rl_pkg::fmt_t    fmt,
  input  ss7rl_pkg::item_t   item,
  output ss7rl_pkg::result_t res
);
  import ss7rl_pkg::*;

  function automatic logic fit_itu(input logic [23:0] code);
    fit_itu = (code[23:19] == 5'd0) && (code[7:3] == 5'd0);
  endfunction

  function automatic logic fit_jpn(input logic [23:0] code);
    fit_jpn = !code[23] && (code[15:12] == 4'd0) && (code[7:5] == 3'd0);
  endfunction

  // ITU point code: 3-bit zone, 8-bit area, 3-bit signalling point
  function automatic logic [23:0] itu_code(input logic [13:0] p);
    itu_code = {5'd0, p[13:11], p[10:3], 5'd0, p[2:0]};
  endfunction

  // Japan point code: the 16-bit field splits into 7-bit, 4-bit and 5-bit parts
  function automatic logic [23:0] jpn_code(input logic [15:0] p);
    jpn_code = {1'b0, p[15:9], 4'd0, p[8:5], 3'd0, p[4:0]};
  endfunction

  function automatic logic [13:0] pack_itu(input logic [23:0] code);
    pack_itu = fit_itu(code) ? {code[18:16], code[15:8], code[2:0]} : 14'd0;
  endfunction

  function automatic logic [15:0] pack_jpn(input logic [23:0] code);
    pack_jpn = fit_jpn(code) ? {code[22:16], code[11:8], code[4:0]} : 16'd0;
  endfunction

  logic [55:0] lb;
  logic [23:0] dpc;
  logic [23:0] opc;
  logic [7:0]  sls;
  logic [7:0]  spr;
  logic        nib_ok;   // SLS and spare fit 4 bits each
  logic        five_ok;  // SLS fits 5 bits, spare 3 bits

  assign lb      = item.label_bytes;
  assign dpc     = item.dest_code;
  assign opc     = item.orig_code;
  assign sls     = item.link_select;
  assign spr     = item.spare;
  assign nib_ok  = (sls[7:4] == 4'd0) && (spr[7:4] == 4'd0);
  assign five_ok = (sls[7:5] == 3'd0) && (spr[7:3] == 5'd0);

  always_comb begin
    res             = '0;
    res.fits_format = 1'b1;
    unique case (fmt)
      FMT_ITU:                res.label_length = LEN_ITU;
      FMT_JAPAN, FMT_JAPAN5:  res.label_length = LEN_JAPAN;
      default:                res.label_length = LEN_WIDE;
    endcase

    if (item.mode == MODE_DECODE) begin
      unique case (fmt)
        FMT_ITU: begin
          res.dest_code   = itu_code(lb[13:0]);
          res.orig_code   = itu_code(lb[27:14]);
          res.link_select = {4'd0, lb[31:28]};
        end
        FMT_ANSI: begin
          res.dest_code   = lb[23:0];
          res.orig_code   = lb[47:24];
          res.link_select = {3'd0, lb[52:48]};
          res.spare       = lb[55:53];
        end
        FMT_ANSI8: begin
          res.dest_code   = lb[23:0];
          res.orig_code   = lb[47:24];
          res.link_select = lb[55:48];
        end
        FMT_CHINA: begin
          res.dest_code   = lb[23:0];
          res.orig_code   = lb[47:24];
          res.link_select = {4'd0, lb[51:48]};
          res.spare       = lb[54:52];
        end
        FMT_JAPAN: begin
          res.dest_code   = jpn_code(lb[15:0]);
          res.orig_code   = jpn_code(lb[31:16]);
          res.link_select = {4'd0, lb[35:32]};
          res.spare       = lb[38:36];
        end
        FMT_JAPAN5: begin
          res.dest_code   = jpn_code(lb[15:0]);
          res.orig_code   = jpn_code(lb[31:16]);
          res.link_select = {3'd0, lb[36:32]};
          res.spare       = lb[39:37];
        end
        default: ;
      endcase
    end else begin
      unique case (fmt)
        FMT_ITU: begin
          res.fits_format = nib_ok && fit_itu(dpc) && fit_itu(opc);
          res.label = {24'd0, sls[3:0], pack_itu(opc), pack_itu(dpc)};
        end
        FMT_ANSI: begin
          res.fits_format = five_ok;
          res.label = {spr[2:0], sls[4:0], opc, dpc};
        end
        FMT_ANSI8: begin
          res.fits_format = (spr == 8'd0);
          res.label = {sls, opc, dpc};
        end
        FMT_CHINA: begin
          res.fits_format = nib_ok;
          res.label = {spr[3:0], sls[3:0], opc, dpc};
        end
        FMT_JAPAN: begin
          res.fits_format = nib_ok && fit_jpn(dpc) && fit_jpn(opc);
          res.label = {16'd0, spr[3:0], sls[3:0], pack_jpn(opc), pack_jpn(dpc)};
        end
        FMT_JAPAN5: begin
          res.fits_format = five_ok && fit_jpn(dpc) && fit_jpn(opc);
          res.label = {16'd0, spr[2:0], sls[4:0], pack_jpn(opc), pack_jpn(dpc)};
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/ss7_routing_label_codec.sv
// ----------------------------------------------------------------------------
// SS7 routing label codec
// Decodes or encodes MTP3 routing labels in ITU, ANSI, ANSI8, China, Japan
// and Japan5 formats.
// ----------------------------------------------------------------------------
// One label per clock while out_tready is high. Each transfer is latched in
// an input register, sliced or packed by combinational logic, and lands in a
// result register. The two registers form a stall-aware pipeline: while a
// finished result waits on out_tready, one more input is taken into the input
// register, and in_tready then stays low until the result moves on. cfg_wen
// selects the format; write it only with no label in flight. Codes 6 and 7
// are ignored.
module ss7_routing_label_codec (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // label_bytes[55:0], dest_code_in[79:56], orig_code_in[103:80],
  // link_select_in[111:104], spare_in[119:112]
  input  logic [119:0] in_tdata,
  // mode[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // label_out[55:0], label_length[58:56], dest_code_out[82:59],
  // orig_code_out[106:83], link_select_out[114:107], spare_out[117:115],
  // fits_format[118], zero[119]
  output logic [119:0] out_tdata
);
  import ss7rl_pkg::*;

  fmt_t    fmt_r;
  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res_nxt;
  logic    adv;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_ITU;
    end else if (cfg_wen && (cfg_wdata <= FMT_JAPAN5)) begin
      fmt_r <= fmt_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= '{mode:        in_tuser,
                     label_bytes: in_tdata[55:0],
                     dest_code:   in_tdata[79:56],
                     orig_code:   in_tdata[103:80],
                     link_select: in_tdata[111:104],
                     spare:       in_tdata[119:112]};
    end
    if (in_valid_r && adv) begin
      out_res_r <= res_nxt;
    end
  end

  ss7rl_codec u_codec (
    .fmt  (fmt_r),
    .item (in_item_r),
    .res  (res_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.fits_format, out_res_r.spare,
                       out_res_r.link_select, out_res_r.orig_code,
                       out_res_r.dest_code, out_res_r.label_length,
                       out_res_r.label};

endmodule

FILE: rtl/core/ss7rl_checker.sv
// ----------------------------------------------------------------------------
// SS7 routing label codec checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "ss7_routing_label_codec_defines.svh"

module ss7rl_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata
);
  import ss7rl_pkg::*;

  logic [2:0]  len_field;
  logic [23:0] hi_octets;

  assign len_field = out_tdata[58:56];
  assign hi_octets = out_tdata[55:32];

  // stalled result must hold
  `SS7RL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  `SS7RL_ASSERT_NOW(a_len_legal, out_tvalid, (len_field == LEN_ITU) || (len_field == LEN_JAPAN) || (len_field == LEN_WIDE))

  // octets past the label length stay zero
  `SS7RL_ASSERT_NOW(a_itu_octets, out_tvalid && (len_field == LEN_ITU), hi_octets == 24'd0)
  `SS7RL_ASSERT_NOW(a_jpn_octets, out_tvalid && (len_field == LEN_JAPAN), hi_octets[23:8] == 16'd0)

  // a failed fit only comes from encode, which leaves decoded fields clear
  `SS7RL_ASSERT_NOW(a_misfit_enc, out_tvalid && !out_tdata[118], out_tdata[117:59] == 59'd0)

endmodule

bind ss7_routing_label_codec ss7rl_checker u_checker (.*);
